@@ src/ska_pkg.sv @@
// shared types and constants for the scalar kalman filter
// no dependencies; used by ska_div, ska_mul and scalar_kalman_filter
`timescale 1ns / 1ps

package ska_pkg;

  // gain is kept as q1.16 internally (0 .. 65536)
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_W     = GAIN_BITS + 1;
  localparam int DATA_W     = 32;
  localparam int DEN_W      = DATA_W + 1;
  localparam int REM_W      = DATA_W + 2;
  localparam int MCAND_W    = DATA_W + 2;
  localparam int ACC_W      = MCAND_W + 1;
  localparam int PROD_W     = ACC_W + GAIN_W;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;

  // last step index of the serial divider and multiplier
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_BITS);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE     = 2'd0,
    CFG_MEASUREMENT_NOISE = 2'd1,
    CFG_INITIAL_ESTIMATE  = 2'd2,
    CFG_INITIAL_VARIANCE  = 2'd3
  } ska_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EST_GO,
    ST_EST,
    ST_VAR_GO,
    ST_VAR,
    ST_OUT
  } ska_state_t;

endpackage

@@ src/ska_div.sv @@
// restoring divider, one quotient bit per cycle, q1.16 quotient of num/den
// uses ska_pkg; requires num <= den
`timescale 1ns / 1ps

module ska_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ska_pkg::DATA_W-1:0]    num,
  input  logic [ska_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [ska_pkg::GAIN_W-1:0]    quo
);

  logic [ska_pkg::DEN_W-1:0]  den_r;
  logic [ska_pkg::REM_W-1:0]  rem_r;
  logic [ska_pkg::GAIN_W-1:0] quo_r;
  logic [ska_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ska_pkg::REM_W-1:0]  trial;
  logic [ska_pkg::REM_W-1:0]  trial_sub;
  logic                       fits;

  // first step compares num itself, later steps the doubled remainder
  always_comb begin
    trial     = (cnt_r == '0) ? rem_r : {rem_r[ska_pkg::REM_W-2:0], 1'b0};
    fits      = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == ska_pkg::LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ska_pkg::LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num};
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub : trial;
      quo_r <= {quo_r[ska_pkg::GAIN_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ src/ska_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle, lsb first
// uses ska_pkg; signed multiplicand times unsigned 17-bit multiplier
`timescale 1ns / 1ps

module ska_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [ska_pkg::MCAND_W-1:0] mcand,
  input  logic [ska_pkg::GAIN_W-1:0]         mplier,
  output logic                               done,
  output logic signed [ska_pkg::PROD_W-1:0]  prod
);

  logic signed [ska_pkg::MCAND_W-1:0] a_r;
  logic [ska_pkg::GAIN_W-1:0]         b_r;
  logic signed [ska_pkg::ACC_W-1:0]   acc_r;
  logic [ska_pkg::GAIN_W-1:0]         lo_r;
  logic [ska_pkg::CNT_W-1:0]          cnt_r;
  logic                               busy_r;
  logic                               done_r;

  logic signed [ska_pkg::ACC_W-1:0]   sum;

  always_comb begin
    sum = acc_r;
    if (b_r[0]) begin
      sum = acc_r + {a_r[ska_pkg::MCAND_W-1], a_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == ska_pkg::LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ska_pkg::LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // low product bits shift out of the accumulator into lo_r
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mcand;
      b_r   <= mplier;
      acc_r <= '0;
      lo_r  <= '0;
    end else if (busy_r) begin
      acc_r <= sum >>> 1;
      lo_r  <= {sum[0], lo_r[ska_pkg::GAIN_W-1:1]};
      b_r   <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = {acc_r, lo_r};

endmodule

@@ src/scalar_kalman_filter.sv @@
// one-dimensional kalman filter over a q16.16 sample stream
// each input transaction is taken in ST_IDLE and runs through ST_PREP, the
// 17-step serial divider and two 17-step passes of the shared serial
// multiplier, then ST_OUT waits for the previous result to be taken; only
// then is the next sample accepted. rst_n is synchronous, active low,
// and loads the noise, estimate and variance registers with their defaults
`timescale 1ns / 1ps

module scalar_kalman_filter #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] sample
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [47:0]                       out_tdata,  // [31:0] filtered_value, [47:32] gain
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [ska_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  // reset values: 1.1, 1.1, 9000.0 (saturated if out of range) and 0.1, rounded to nearest
  localparam logic [63:0] NOISE_FULL = ((64'd11 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] VAR_FULL   = ((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] EST_FULL   = 64'd9000 << FRACTION_BITS;
  localparam logic [31:0] RESET_NOISE    = NOISE_FULL[31:0];
  localparam logic [31:0] RESET_VARIANCE = VAR_FULL[31:0];
  localparam logic [31:0] RESET_ESTIMATE =
    (EST_FULL > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : EST_FULL[31:0];

  localparam int D = ska_pkg::DATA_W;

  // configuration and filter state
  logic [D-1:0]        pn_r;
  logic [D-1:0]        mn_r;
  logic signed [D-1:0] est_r;
  logic [D-1:0]        var_r;

  // per-transaction working registers
  logic signed [D-1:0]             sample_r;
  logic [D-1:0]                    v_r;
  logic [ska_pkg::GAIN_W-1:0]      g_r;

  // output register
  logic                            out_valid_r;
  logic [D-1:0]                    out_est_r;
  logic [ska_pkg::GAIN_BITS-1:0]   out_gain_r;

  ska_pkg::ska_state_t state_r, state_nxt;

  // datapath signals
  logic                                 in_xfer;
  logic                                 out_free;
  logic [D:0]                           v_sum;
  logic [D-1:0]                         v_sat;
  logic [ska_pkg::DEN_W-1:0]            den;
  logic                                 den_zero;
  logic                                 div_start;
  logic                                 div_done;
  logic [ska_pkg::GAIN_W-1:0]           div_quo;
  logic                                 mul_start;
  logic                                 mul_done;
  logic signed [ska_pkg::MCAND_W-1:0]   mul_a;
  logic [ska_pkg::GAIN_W-1:0]           mul_b;
  logic signed [ska_pkg::PROD_W-1:0]    mul_p;
  logic signed [D:0]                    diff;
  logic [ska_pkg::PROD_W-1:0]           rnd;
  logic [D+3:0]                         delta;
  logic [D+4:0]                         est_sum;
  logic [D-1:0]                         est_new;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // predicted variance with saturation at all ones
  assign v_sum = {1'b0, var_r} + {1'b0, pn_r};
  assign v_sat = v_sum[D] ? '1 : v_sum[D-1:0];

  // gain denominator, exact in 33 bits; zero only when v and r are both zero
  assign den      = {1'b0, v_r} + {1'b0, mn_r};
  assign den_zero = (v_r == '0) && (mn_r == '0);

  // innovation, exact in 33 bits
  assign diff = $signed({sample_r[D-1], sample_r}) - $signed({est_r[D-1], est_r});

  // shared multiplier: gain * innovation, then v * (1 - gain)
  always_comb begin
    if (state_r == ska_pkg::ST_EST_GO) begin
      mul_a = {diff[D], diff};
      mul_b = g_r;
    end else begin
      mul_a = {2'b00, v_r};
      mul_b = ska_pkg::GAIN_ONE - g_r;
    end
  end

  // round to nearest, ties up, then floor shift and saturating add
  always_comb begin
    rnd     = mul_p + ska_pkg::ROUND_HALF;
    delta   = rnd[ska_pkg::PROD_W-1:ska_pkg::GAIN_BITS];
    est_sum = {{5{est_r[D-1]}}, est_r} + {delta[D+3], delta};
    if (!est_sum[D+4] && (est_sum[D+3:D-1] != '0)) begin
      est_new = {1'b0, {(D-1){1'b1}}};
    end else if (est_sum[D+4] && (est_sum[D+3:D-1] != '1)) begin
      est_new = {1'b1, {(D-1){1'b0}}};
    end else begin
      est_new = est_sum[D-1:0];
    end
  end

  ska_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (v_r),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  ska_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_p)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ska_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ska_pkg::ST_PREP;
        end
      end
      ska_pkg::ST_PREP:   state_nxt = ska_pkg::ST_DIV;
      ska_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ska_pkg::ST_EST_GO;
        end
      end
      ska_pkg::ST_EST_GO: state_nxt = ska_pkg::ST_EST;
      ska_pkg::ST_EST: begin
        if (mul_done) begin
          state_nxt = ska_pkg::ST_VAR_GO;
        end
      end
      ska_pkg::ST_VAR_GO: state_nxt = ska_pkg::ST_VAR;
      ska_pkg::ST_VAR: begin
        if (mul_done) begin
          state_nxt = ska_pkg::ST_OUT;
        end
      end
      ska_pkg::ST_OUT: begin
        // wait here until the previous result has been taken
        if (out_free) begin
          state_nxt = ska_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ska_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (state_r)
      ska_pkg::ST_IDLE:   in_tready = 1'b1;
      ska_pkg::ST_PREP:   div_start = 1'b1;
      ska_pkg::ST_EST_GO: mul_start = 1'b1;
      ska_pkg::ST_VAR_GO: mul_start = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ska_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers and filter state; the user must write config only while idle,
  // the block does not enforce it; writing an initial register loads the live state directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= RESET_NOISE;
      mn_r  <= RESET_NOISE;
      est_r <= RESET_ESTIMATE;
      var_r <= RESET_VARIANCE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ska_pkg::CFG_PROCESS_NOISE:     pn_r  <= cfg_wdata;
        ska_pkg::CFG_MEASUREMENT_NOISE: mn_r  <= cfg_wdata;
        ska_pkg::CFG_INITIAL_ESTIMATE:  est_r <= cfg_wdata;
        ska_pkg::CFG_INITIAL_VARIANCE:  var_r <= cfg_wdata;
        default: begin
          pn_r <= pn_r;
        end
      endcase
    end else begin
      if ((state_r == ska_pkg::ST_EST) && mul_done) begin
        est_r <= est_new;
      end
      // new variance is floor(v * (1 - g)), always below 2^32
      if ((state_r == ska_pkg::ST_VAR) && mul_done) begin
        var_r <= mul_p[ska_pkg::GAIN_BITS+D-1:ska_pkg::GAIN_BITS];
      end
    end
  end

  // working registers of one transaction
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_tdata;
      v_r      <= v_sat;
    end
    if ((state_r == ska_pkg::ST_DIV) && div_done) begin
      g_r <= den_zero ? '0 : div_quo;
    end
  end

  // output register; gain of exactly one reads as all ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ska_pkg::ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ska_pkg::ST_OUT) && out_free) begin
      out_est_r  <= est_r;
      out_gain_r <= g_r[ska_pkg::GAIN_BITS] ? '1 : g_r[ska_pkg::GAIN_BITS-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_gain_r, out_est_r};

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for scalar_kalman_filter: directed corner cases, then random
// samples and register settings, checked against a bit-exact estimate tracker
// depends on src/ska_pkg.sv and src/scalar_kalman_filter.sv
`timescale 1ns / 1ps

module testbench;

  // default register values in q16.16 (1.1, 9000.0 and 0.1)
  localparam logic [31:0] DEFAULT_NOISE    = 32'd72090;
  localparam logic [31:0] DEFAULT_ESTIMATE = 32'd589824000;
  localparam logic [31:0] DEFAULT_VARIANCE = 32'd6554;
  localparam logic [31:0] S32_MAX          = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN          = 32'h8000_0000;
  localparam logic [31:0] U32_MAX          = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS  = 1350;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_OFF_AT   = 400;   // results seen before the long receiver hold-off
  localparam int HOLD_OFF_LEN  = 4000;
  localparam int SETTLE_CYCLES = 100;   // settle time before the final check

  typedef struct packed {
    logic [15:0] gain;
    logic [31:0] filtered_value;
  } estimate_t;

  // tracks the filter state and holds the estimates still to come out
  class estimate_tracker;
    logic [31:0]        process_noise;
    logic [31:0]        measurement_noise;
    logic signed [31:0] estimate;
    logic [31:0]        error_variance;
    estimate_t          pending_estimates[$];
    int                 failures;
    int                 checked;

    function new();
      process_noise     = DEFAULT_NOISE;
      measurement_noise = DEFAULT_NOISE;
      estimate          = DEFAULT_ESTIMATE;
      error_variance    = DEFAULT_VARIANCE;
      failures          = 0;
      checked           = 0;
    endfunction

    function void set_register(ska_pkg::ska_cfg_t idx, logic [31:0] value);
      case (idx)
        ska_pkg::CFG_PROCESS_NOISE:     process_noise = value;
        ska_pkg::CFG_MEASUREMENT_NOISE: measurement_noise = value;
        ska_pkg::CFG_INITIAL_ESTIMATE:  estimate = value;
        ska_pkg::CFG_INITIAL_VARIANCE:  error_variance = value;
        default: ;
      endcase
    endfunction

    // one filter step for an accepted sample
    function void take_sample(logic [31:0] sample);
      longint unsigned v;
      longint unsigned den;
      longint unsigned g;
      longint          diff;
      longint          prod;
      longint          next_est;
      estimate_t       item;
      v = 64'(error_variance) + 64'(process_noise);
      if (v > 64'(U32_MAX)) v = 64'(U32_MAX);
      den = v + 64'(measurement_noise);
      g = (den == 0) ? 64'd0 : (v << ska_pkg::GAIN_BITS) / den;
      diff = longint'($signed(sample)) - longint'(estimate);
      prod = $signed(g) * diff + (longint'(1) << (ska_pkg::GAIN_BITS - 1));
      next_est = longint'(estimate) + (prod >>> ska_pkg::GAIN_BITS);
      if (next_est > longint'($signed(S32_MAX))) next_est = longint'($signed(S32_MAX));
      if (next_est < longint'($signed(S32_MIN))) next_est = longint'($signed(S32_MIN));
      estimate = next_est[31:0];
      error_variance = 32'((v * ((64'd1 << ska_pkg::GAIN_BITS) - g)) >> ska_pkg::GAIN_BITS);
      item.filtered_value = estimate;
      item.gain = (g > 64'hFFFF) ? 16'hFFFF : g[15:0];
      pending_estimates.push_back(item);
    endfunction

    function void check_estimate(logic [47:0] tdata);
      estimate_t want;
      estimate_t got;
      got = tdata;
      checked++;
      if (pending_estimates.size() == 0) begin
        $error("result with no pending estimate: filtered_value %0d, gain %0d",
               $signed(got.filtered_value), got.gain);
        failures++;
        return;
      end
      want = pending_estimates.pop_front();
      if (got.filtered_value !== want.filtered_value) begin
        $error("filtered_value mismatch: expected %0d, actual %0d",
               $signed(want.filtered_value), $signed(got.filtered_value));
        failures++;
      end
      if (got.gain !== want.gain) begin
        $error("gain mismatch: expected %0d, actual %0d", want.gain, got.gain);
        failures++;
      end
    endfunction

    function int pending();
      return pending_estimates.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [31:0]                   in_tdata;    // [31:0] sample
  logic                          out_tvalid;
  logic                          out_tready;
  logic [47:0]                   out_tdata;   // [31:0] filtered_value, [47:32] gain
  logic                          cfg_wr_en;
  logic [ska_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_wdata;

  estimate_tracker tracker = new();
  int              cycle_count = 0;
  int              burst_left = 0;

  scalar_kalman_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register write, called at a falling edge while the filter is idle
  task automatic write_register(ska_pkg::ska_cfg_t idx, logic [31:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    tracker.set_register(idx, value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // offer one sample; the sender works in bursts with random gaps between them.
  // called at a falling edge, returns at the falling edge after the transaction
  task automatic drive_sample(logic [31:0] sample);
    int gap;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      // a third of the bursts follow the previous one with no gap at all
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid = 1'b1;
    in_tdata  = sample;
    do @(posedge clk); while (!in_tready);
    tracker.take_sample(sample);
    @(negedge clk);
    burst_left--;
  endtask

  // stop offering and wait until every estimate has come out and the filter is idle
  task automatic drain();
    in_tvalid  = 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.pending() != 0 || !in_tready);
    @(negedge clk);
  endtask

  // register value: extremes, small noise-like values, powers of two or anything
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return U32_MAX;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom;
      4:       return $urandom_range(1, 255);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  // mostly noisy readings around a center, with some full-range and extreme values
  function automatic logic [31:0] pick_sample(logic [31:0] center);
    logic [31:0] noise;
    noise = $urandom;
    noise = $signed(noise) >>> $urandom_range(8, 28);
    case ($urandom_range(0, 19))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return 32'd0;
      3, 4, 5: return $urandom;
      default: return center + noise;
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int          sent;
    int          phase_len;
    logic [31:0] center;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = ska_pkg::CFG_PROCESS_NOISE;
    cfg_wdata  = '0;
    sent       = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // default settings, extremes of the sample
    drive_sample(S32_MAX);
    drive_sample(S32_MIN);
    drive_sample(32'd0);
    drive_sample(U32_MAX);
    drive_sample(32'd1);
    drain();

    // zero denominator: no noise and no variance, gain stays 0
    write_register(ska_pkg::CFG_PROCESS_NOISE, 32'd0);
    write_register(ska_pkg::CFG_MEASUREMENT_NOISE, 32'd0);
    write_register(ska_pkg::CFG_INITIAL_VARIANCE, 32'd0);
    drive_sample(32'd12345 << 16);
    drive_sample(S32_MIN);
    drain();

    // gain of exactly one: no measurement noise, estimate jumps to the sample
    write_register(ska_pkg::CFG_PROCESS_NOISE, 32'd1);
    drive_sample(S32_MAX);
    drive_sample(S32_MIN);
    drive_sample(32'h0001_8000);
    drain();

    // variance saturation with everything at the top
    write_register(ska_pkg::CFG_PROCESS_NOISE, U32_MAX);
    write_register(ska_pkg::CFG_MEASUREMENT_NOISE, U32_MAX);
    write_register(ska_pkg::CFG_INITIAL_VARIANCE, U32_MAX);
    drive_sample(S32_MAX);
    drive_sample(32'd0);
    drain();

    // estimate at both ends of the range, swinging to the far end
    write_register(ska_pkg::CFG_PROCESS_NOISE, 32'h0001_0000);
    write_register(ska_pkg::CFG_MEASUREMENT_NOISE, 32'd1);
    write_register(ska_pkg::CFG_INITIAL_ESTIMATE, S32_MAX);
    drive_sample(S32_MIN);
    drain();
    write_register(ska_pkg::CFG_INITIAL_ESTIMATE, S32_MIN);
    drive_sample(S32_MAX);
    drive_sample(S32_MAX);
    drain();

    // random phases, each with its own register settings and signal level
    while (sent < RANDOM_ITEMS) begin
      center = $urandom;
      center = $signed(center) >>> $urandom_range(0, 16);
      if ($urandom_range(0, 1)) write_register(ska_pkg::CFG_PROCESS_NOISE, pick_word());
      if ($urandom_range(0, 1)) write_register(ska_pkg::CFG_MEASUREMENT_NOISE, pick_word());
      if ($urandom_range(0, 1)) begin
        write_register(ska_pkg::CFG_INITIAL_ESTIMATE,
                       $urandom_range(0, 3) ? center : $urandom);
      end
      if ($urandom_range(0, 1)) write_register(ska_pkg::CFG_INITIAL_VARIANCE, pick_word());
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        drive_sample(pick_sample(center));
        sent++;
      end
      // the sender pauses here until every estimate is back
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // receiver: stretches of always-ready, light stalls, heavy stalls and a fixed
  // pattern, plus one long hold-off so the filter backs up and stalls its input
  initial begin : receiver
    int span;
    int mode;
    bit held_off;
    held_off   = 1'b0;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held_off && tracker.checked >= HOLD_OFF_AT) begin
        held_off   = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 400);
      repeat (span) begin
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 3) != 0);
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = ((cycle_count % 7) < 3);
        endcase
        @(negedge clk);
      end
    end
  end

  // result monitor: every result transaction is checked against the oldest estimate
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_estimate(out_tdata);
    end
  end

  // cycle counter, ends a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

endmodule
